// File: design/srme_pkg.sv
// shared types and constants for the six register machine executor
// no dependencies

package srme_pkg;

	localparam int NUM_REGS   = 6;
	localparam int REG_IDX_W  = $clog2(NUM_REGS);
	localparam int WORD_W     = 32;
	localparam int IP_SEL_W   = 3;
	localparam int PROG_LEN_W = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = PROG_LEN_W;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IP_REGISTER    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_LENGTH = 1'd1;

	typedef enum logic [3:0] {
		OP_ADDR = 4'd0,
		OP_ADDI = 4'd1,
		OP_MULR = 4'd2,
		OP_MULI = 4'd3,
		OP_BANR = 4'd4,
		OP_BANI = 4'd5,
		OP_BORR = 4'd6,
		OP_BORI = 4'd7,
		OP_SETR = 4'd8,
		OP_SETI = 4'd9,
		OP_GTIR = 4'd10,
		OP_GTRI = 4'd11,
		OP_GTRR = 4'd12,
		OP_EQIR = 4'd13,
		OP_EQRI = 4'd14,
		OP_EQRR = 4'd15
	} opcode_t;

	typedef struct packed {
		opcode_t                   op;
		logic signed [WORD_W-1:0]  operand_a;
		logic signed [WORD_W-1:0]  operand_b;
		logic [2:0]                dest_reg;
	} srme_in_t;

	typedef struct packed {
		logic signed [WORD_W-1:0]  next_ip;
		logic                      halted;
		logic signed [WORD_W-1:0]  reg0_value;
		logic                      fault;
	} srme_out_t;

endpackage

// File: design/six_register_machine_executor_unit.sv
// top level: execute unit of the six register machine with a bound pointer register
// depends on srme_pkg (types, opcodes, register indexes)
//
// order: the instruction word is registered in the input stage, then the result
//   word is registered in the output register when the stage advances
// throughput: one instruction word per cycle while out_stall is low; the register
//   file read, alu and write back share a stage; a dependent word follows directly
// reset: clears the register file, ip_register, program_length and all valid flags
//   at once; no clearing pass, the block takes words right after reset

module six_register_machine_executor_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_wr_en,
	input  logic [srme_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [srme_pkg::CFG_DATA_W-1:0]       cfg_data,
	// instruction words in
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  srme_pkg::srme_in_t                    in_data,
	// result words out
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output srme_pkg::srme_out_t                   out_data
);
	import srme_pkg::*;

	// configuration registers
	logic [IP_SEL_W-1:0]   ip_sel_q;
	logic [PROG_LEN_W-1:0] prog_len_q;

	// input stage
	logic     valid_s1;
	srme_in_t instr_s1;

	// architectural register file, one flop row per register
	logic [NUM_REGS-1:0][WORD_W-1:0] rf_q;
	logic [NUM_REGS-1:0][WORD_W-1:0] rf_d;

	// output register
	logic      out_valid_q;
	srme_out_t out_q;
	srme_out_t res;

	logic in_accept;
	logic adv;

	// execute decode
	logic                 a_is_reg;
	logic                 b_is_reg;
	logic                 ip_ok;
	logic                 a_ok;
	logic                 b_ok;
	logic                 dest_ok;
	logic                 op_fault;
	logic [REG_IDX_W-1:0] ip_idx;
	logic [REG_IDX_W-1:0] a_idx;
	logic [REG_IDX_W-1:0] b_idx;
	logic [REG_IDX_W-1:0] dest_idx;
	logic [WORD_W-1:0]    ra;
	logic [WORD_W-1:0]    rb;
	logic [WORD_W-1:0]    imm_a;
	logic [WORD_W-1:0]    imm_b;
	logic [WORD_W-1:0]    alu_r;
	logic [WORD_W-1:0]    ip_base;
	logic [WORD_W-1:0]    nip;

	// the stage advances when the output register is free or being drained
	assign adv       = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign in_accept = in_valid && !in_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// config writes must arrive only while the block is idle; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_sel_q   <= '0;
			prog_len_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_IP_REGISTER:    ip_sel_q   <= cfg_data[IP_SEL_W-1:0];
				CFG_PROGRAM_LENGTH: prog_len_q <= cfg_data;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			instr_s1 <= in_data;
		end
	end

	// which operands the opcode takes as register indexes
	always_comb begin
		a_is_reg = !(instr_s1.op == OP_SETI || instr_s1.op == OP_GTIR ||
			instr_s1.op == OP_EQIR);
		unique case (instr_s1.op)
			OP_ADDR, OP_MULR, OP_BANR, OP_BORR,
			OP_GTIR, OP_GTRR, OP_EQIR, OP_EQRR: b_is_reg = 1'b1;
			default:                            b_is_reg = 1'b0;
		endcase
	end

	// range checks: operands are taken unsigned so negatives fail too
	assign ip_ok   = 32'(ip_sel_q) < NUM_REGS;
	assign a_ok    = !a_is_reg || (unsigned'(instr_s1.operand_a) < WORD_W'(NUM_REGS));
	assign b_ok    = !b_is_reg || (unsigned'(instr_s1.operand_b) < WORD_W'(NUM_REGS));
	assign dest_ok = 32'(instr_s1.dest_reg) < NUM_REGS;
	assign op_fault = !ip_ok || !a_ok || !b_ok || !dest_ok;

	assign ip_idx   = REG_IDX_W'(ip_sel_q);
	assign a_idx    = instr_s1.operand_a[REG_IDX_W-1:0];
	assign b_idx    = instr_s1.operand_b[REG_IDX_W-1:0];
	assign dest_idx = REG_IDX_W'(instr_s1.dest_reg);

	// register reads; out-of-range indexes never reach a write
	assign ra    = rf_q[a_idx];
	assign rb    = rf_q[b_idx];
	assign imm_a = instr_s1.operand_a;
	assign imm_b = instr_s1.operand_b;

	// alu, comparisons signed, multiply keeps the low word
	always_comb begin
		unique case (instr_s1.op)
			OP_ADDR: alu_r = ra + rb;
			OP_ADDI: alu_r = ra + imm_b;
			OP_MULR: alu_r = ra * rb;
			OP_MULI: alu_r = ra * imm_b;
			OP_BANR: alu_r = ra & rb;
			OP_BANI: alu_r = ra & imm_b;
			OP_BORR: alu_r = ra | rb;
			OP_BORI: alu_r = ra | imm_b;
			OP_SETR: alu_r = ra;
			OP_SETI: alu_r = imm_a;
			OP_GTIR: alu_r = WORD_W'($signed(imm_a) > $signed(rb));
			OP_GTRI: alu_r = WORD_W'($signed(ra) > $signed(imm_b));
			OP_GTRR: alu_r = WORD_W'($signed(ra) > $signed(rb));
			OP_EQIR: alu_r = WORD_W'(imm_a == rb);
			OP_EQRI: alu_r = WORD_W'(ra == imm_b);
			OP_EQRR: alu_r = WORD_W'(ra == rb);
		endcase
	end

	// the bound register picks up the alu result first when it is the destination
	assign ip_base = (dest_idx == ip_idx) ? alu_r : rf_q[ip_idx];
	assign nip     = ip_base + WORD_W'(1);

	// next register file: destination write then pointer increment
	always_comb begin
		rf_d = rf_q;
		if (!op_fault) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				if (REG_IDX_W'(i) == ip_idx) begin
					rf_d[i] = nip;
				end else if (REG_IDX_W'(i) == dest_idx) begin
					rf_d[i] = alu_r;
				end
			end
		end
	end

	// result word
	always_comb begin
		res.reg0_value = rf_d[0];
		res.fault      = op_fault;
		if (!ip_ok) begin
			// bad bound register reports pointer zero
			res.next_ip = '0;
			res.halted  = 1'b1;
		end else if (op_fault) begin
			// bad operand or destination: pointer held, machine halts
			res.next_ip = rf_q[ip_idx];
			res.halted  = 1'b1;
		end else begin
			res.next_ip = nip;
			res.halted  = nip[WORD_W-1] || (nip >= WORD_W'(prog_len_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_q <= '0;
		end else if (adv) begin
			rf_q <= rf_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	// a faulting word must leave the register file untouched
	a_fault_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		adv && op_fault |=> $stable(rf_q))
		else $error("register file changed on a faulting word");

	// every executed word lands in the output register
	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("executed word did not reach the output register");

	// a fault always reports halt
	a_fault_halts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.fault |-> out_q.halted)
		else $error("fault reported without halt");

	// a running machine never points at a negative address
	a_run_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.halted |-> !out_q.next_ip[WORD_W-1] && !out_q.fault)
		else $error("running result with negative pointer or fault");

	// input only stalls while an instruction waits in the input stage
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled with nothing blocking");

endmodule
